// ----- hdl/utf8_to_utf16_bmp_decoder_defines.svh -----
// Assertion macros for the port-level checker of the UTF-8 decoder.
// No dependencies; include once per file that asserts.
`ifndef UTF8_TO_UTF16_BMP_DECODER_DEFINES_SVH
`define UTF8_TO_UTF16_BMP_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define U8D_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define U8D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/u8d_pkg.sv -----
// Package for the UTF-8 to UTF-16 BMP decoder: byte-class constants,
// hold-state and result types. No dependencies.
package u8d_pkg;

    localparam int NumSlots = 3;

    localparam logic [7:0]  LEAD2_MASK = 8'hE0;
    localparam logic [7:0]  LEAD2_TAG  = 8'hC0;
    localparam logic [7:0]  LEAD3_MASK = 8'hF0;
    localparam logic [7:0]  LEAD3_TAG  = 8'hE0;
    localparam logic [7:0]  CONT_MASK  = 8'hC0;
    localparam logic [7:0]  CONT_TAG   = 8'h80;
    localparam logic [7:0]  LOW5_MASK  = 8'h1F;
    localparam logic [7:0]  LOW6_MASK  = 8'h3F;
    localparam logic [7:0]  LOW4_MASK  = 8'h0F;
    localparam logic [15:0] CAP_RESET  = 16'd256;

    // Number of bytes buffered toward a multi-byte sequence
    typedef enum logic [1:0] {
        HOLD_NONE = 2'd0,
        HOLD_LEAD = 2'd1,
        HOLD_BOTH = 2'd2
    } t_hold_cnt;

    typedef struct packed {
        logic [7:0]  lead;
        logic [7:0]  cont;
        t_hold_cnt   count;
        logic [15:0] written;
    } t_hold;

    // Up to three units caused by one byte, slot 0 goes out first
    typedef struct packed {
        logic [NumSlots-1:0][15:0] unit;
        logic [NumSlots-1:0]       term;
        logic [1:0]                count;
    } t_dec_result;

endpackage

// ----- hdl/u8d_decode.sv -----
// Single-pass decode of one byte against the hold state: produces the
// result units and the next hold state. Depends on u8d_pkg.
module u8d_decode (
    input  logic [7:0]          i_byte,
    input  u8d_pkg::t_hold      i_hold,
    input  logic [15:0]         i_limit,
    output u8d_pkg::t_dec_result o_res,
    output u8d_pkg::t_hold      o_hold
);

    logic        byte_zero;
    logic        byte_lead2;
    logic        byte_lead3;
    logic        byte_cont;
    logic        held_lead2;
    logic        held_lead3;
    logic [15:0] lead_unit;
    logic [15:0] cont_unit;
    logic [15:0] comb2_unit;
    logic [15:0] comb3_unit;

    logic [15:0] cand0;
    logic [15:0] cand1;
    logic [1:0]  cand_n;
    logic        fresh;
    logic        hold_cont;

    logic [15:0] room;
    logic [1:0]  avail;
    logic [1:0]  k;
    logic        fresh_ok;
    logic        raw_emit;

    // Classify the new byte and the held lead
    assign byte_zero  = (i_byte == 8'h00);
    assign byte_lead2 = ((i_byte & u8d_pkg::LEAD2_MASK) == u8d_pkg::LEAD2_TAG);
    assign byte_lead3 = ((i_byte & u8d_pkg::LEAD3_MASK) == u8d_pkg::LEAD3_TAG);
    assign byte_cont  = ((i_byte & u8d_pkg::CONT_MASK) == u8d_pkg::CONT_TAG);
    assign held_lead2 = ((i_hold.lead & u8d_pkg::LEAD2_MASK) == u8d_pkg::LEAD2_TAG);
    assign held_lead3 = ((i_hold.lead & u8d_pkg::LEAD3_MASK) == u8d_pkg::LEAD3_TAG);

    assign lead_unit  = {8'h00, i_hold.lead};
    assign cont_unit  = {8'h00, i_hold.cont};
    assign comb2_unit = {5'b0, 5'(i_hold.lead & u8d_pkg::LOW5_MASK),
                         6'(i_byte & u8d_pkg::LOW6_MASK)};
    assign comb3_unit = {4'(i_hold.lead & u8d_pkg::LOW4_MASK),
                         6'(i_hold.cont & u8d_pkg::LOW6_MASK),
                         6'(i_byte & u8d_pkg::LOW6_MASK)};

    // Pick the units this byte would emit before any fresh-byte handling
    always_comb begin
        cand0     = lead_unit;
        cand1     = cont_unit;
        cand_n    = 2'd0;
        fresh     = 1'b0;
        hold_cont = 1'b0;
        if (byte_zero) begin
            case (i_hold.count)
                u8d_pkg::HOLD_LEAD: cand_n = 2'd1;
                u8d_pkg::HOLD_BOTH: cand_n = 2'd2;
                default:            cand_n = 2'd0;
            endcase
        end else begin
            case (i_hold.count)
                u8d_pkg::HOLD_LEAD: begin
                    if (held_lead2 && byte_cont) begin
                        cand0  = comb2_unit;
                        cand_n = 2'd1;
                    end else if (held_lead3 && byte_cont) begin
                        hold_cont = 1'b1;
                    end else begin
                        cand_n = 2'd1;
                        fresh  = 1'b1;
                    end
                end
                u8d_pkg::HOLD_BOTH: begin
                    if (byte_cont) begin
                        cand0  = comb3_unit;
                        cand_n = 2'd1;
                    end else begin
                        cand_n = 2'd2;
                        fresh  = 1'b1;
                    end
                end
                default: begin
                    fresh = 1'b1;
                end
            endcase
        end
    end

    // Room left before the buffer is full, capped at the slot count
    assign room  = (i_hold.written < i_limit) ? (i_limit - i_hold.written) : 16'd0;
    assign avail = (room >= 16'd3) ? 2'd3 : room[1:0];
    assign k     = (cand_n < avail) ? cand_n : avail;
    assign fresh_ok = fresh && (k < avail);
    assign raw_emit = fresh_ok && !(byte_lead2 || byte_lead3);

    // Place units, then the raw byte or the terminator right after them
    always_comb begin
        o_res.unit    = '0;
        o_res.term    = '0;
        o_res.unit[0] = cand0;
        o_res.unit[1] = cand1;
        o_res.count   = k;
        if (raw_emit) begin
            o_res.unit[k] = {8'h00, i_byte};
            o_res.count   = k + 2'd1;
        end else if (byte_zero) begin
            o_res.unit[k] = 16'h0000;
            o_res.term[k] = 1'b1;
            o_res.count   = k + 2'd1;
        end
    end

    // Next hold state
    always_comb begin
        o_hold         = i_hold;
        o_hold.count   = u8d_pkg::HOLD_NONE;
        o_hold.written = i_hold.written + 16'(k) + 16'(raw_emit);
        if (byte_zero) begin
            o_hold.lead    = 8'h00;
            o_hold.cont    = 8'h00;
            o_hold.written = 16'd0;
        end else if (hold_cont) begin
            o_hold.cont  = i_byte;
            o_hold.count = u8d_pkg::HOLD_BOTH;
        end else if (fresh_ok && (byte_lead2 || byte_lead3)) begin
            o_hold.lead  = i_byte;
            o_hold.count = u8d_pkg::HOLD_LEAD;
        end
    end

endmodule

// ----- hdl/utf8_to_utf16_bmp_decoder.sv -----
// Top level of the UTF-8 to UTF-16 BMP stream decoder: hold state,
// capacity register and a three-entry result buffer. Depends on u8d_pkg, u8d_decode.
//
//  channel   dir  tdata               tuser          tlast
//  s_axis    in   [7:0] in_byte       -              -
//  m_axis    out  [15:0] code_unit    is_terminator  run_last
//  cfg       in   i_cfg_data[15:0] = out_capacity, written when i_cfg_we
//
// One byte is decoded combinationally per transfer; its results land in the buffer
// in the next cycle and leave at one unit per cycle while m_axis_tready is high.
// A byte with one result sustains one byte per cycle while the output does not stall;
// a byte with two or three results holds the input until its last unit is leaving.
// Reset (synchronous, i_rst_n low) clears the hold state and sets capacity to 256.
// Output stalls back up to s_axis_tready whenever the buffer is not empty.
module utf8_to_utf16_bmp_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] code_unit
    output logic        m_axis_tuser,   // [0] is_terminator
    output logic        m_axis_tlast
);

    u8d_pkg::t_hold       r_hold;
    u8d_pkg::t_hold       n_hold;
    u8d_pkg::t_dec_result dec_res;
    logic [15:0]          r_cap;
    logic [15:0]          limit;

    logic [u8d_pkg::NumSlots-1:0][15:0] r_unit;
    logic [u8d_pkg::NumSlots-1:0][15:0] n_unit;
    logic [u8d_pkg::NumSlots-1:0]       r_term;
    logic [u8d_pkg::NumSlots-1:0]       n_term;
    logic [u8d_pkg::NumSlots-1:0]       r_last;
    logic [u8d_pkg::NumSlots-1:0]       n_last;
    logic [1:0]                         r_cnt;
    logic [1:0]                         n_cnt;

    logic in_xfer;
    logic out_xfer;

    // Capacity zero behaves as capacity one
    assign limit = (r_cap == 16'd0) ? 16'd0 : (r_cap - 16'd1);

    u8d_decode u_decode (
        .i_byte  (s_axis_tdata),
        .i_hold  (r_hold),
        .i_limit (limit),
        .o_res   (dec_res),
        .o_hold  (n_hold)
    );

    // Accept while the buffer is empty or its last unit leaves this cycle
    assign s_axis_tready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && m_axis_tready);
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = r_unit[0];
    assign m_axis_tuser  = r_term[0];
    assign m_axis_tlast  = r_last[0];

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // Shift the buffer on each output transfer, load it on each input transfer
    always_comb begin
        n_unit = r_unit;
        n_term = r_term;
        n_last = r_last;
        n_cnt  = r_cnt;
        if (out_xfer) begin
            n_unit = {16'h0000, r_unit[2], r_unit[1]};
            n_term = {1'b0, r_term[2:1]};
            n_last = {1'b0, r_last[2:1]};
            n_cnt  = r_cnt - 2'd1;
        end
        if (in_xfer) begin
            n_unit = dec_res.unit;
            n_term = dec_res.term;
            n_cnt  = dec_res.count;
            for (int i = 0; i < u8d_pkg::NumSlots; i++) begin
                n_last[i] = (dec_res.count == 2'(i + 1));
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_hold <= '0;
            r_cap  <= u8d_pkg::CAP_RESET;
        end else begin
            r_cnt <= n_cnt;
            if (in_xfer) begin
                r_hold <= n_hold;
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_unit <= n_unit;
        r_term <= n_term;
        r_last <= n_last;
    end

endmodule

// ----- hdl/u8d_checker.sv -----
// Port-level checker for the UTF-8 decoder and its bind to the top level.
// Depends on utf8_to_utf16_bmp_decoder_defines.svh.
`include "utf8_to_utf16_bmp_decoder_defines.svh"

module u8d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled output transfer keeps its unit
    `U8D_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output unit changed")

    // The terminator is a zero unit and always closes its byte's results
    `U8D_ASSERT_NOW(a_term_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, (m_axis_tdata == 16'h0000) && m_axis_tlast, "terminator not a final zero unit")

    // A zero byte always yields output in the next cycle
    `U8D_ASSERT_NEXT(a_zero_out, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tdata == 8'h00), m_axis_tvalid, "zero byte gave no terminator")

    // Input backpressure only comes from pending results
    `U8D_ASSERT_NOW(a_ready_cause, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid, "input stalled with nothing pending")

endmodule

bind utf8_to_utf16_bmp_decoder u8d_checker u_u8d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- sim/utf8_to_utf16_bmp_decoder_tb.sv -----
// Self-checking testbench for utf8_to_utf16_bmp_decoder: directed byte strings, then random
// strings under several capacities, with random stalls on both stream sides.
// Depends on u8d_pkg (hold-count enum) and the decoder top level.
module utf8_to_utf16_bmp_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One decoded unit as it should leave the block
    typedef struct packed {
        logic [15:0] unit;
        logic        term;
        logic        last;
    } t_unit_result;

    // Decoder model plus the queue of units it predicts
    class utf16_scoreboard;
        logic [15:0]        capacity;
        logic [7:0]         held_lead;
        logic [7:0]         held_cont;
        u8d_pkg::t_hold_cnt hold_cnt;
        logic [15:0]        units;
        t_unit_result       expected_units[$];
        t_unit_result       staged[3];
        int                 n_staged;
        int                 errors;

        function new();
            capacity  = 16'd256;
            held_lead = '0;
            held_cont = '0;
            hold_cnt  = u8d_pkg::HOLD_NONE;
            units     = '0;
            errors    = 0;
        endfunction

        function void set_capacity(logic [15:0] v);
            capacity = v;
        endfunction

        function int pending();
            return expected_units.size();
        endfunction

        function logic is_lead2(logic [7:0] b);
            return (b & 8'hE0) == 8'hC0;
        endfunction

        function logic is_lead3(logic [7:0] b);
            return (b & 8'hF0) == 8'hE0;
        endfunction

        function logic is_cont(logic [7:0] b);
            return (b & 8'hC0) == 8'h80;
        endfunction

        function logic buffer_full();
            logic [15:0] limit;
            limit = (capacity == 16'd0) ? 16'd0 : capacity - 16'd1;
            return units >= limit;
        endfunction

        function void stage(logic [15:0] unit, logic term);
            if (n_staged < 3) begin
                staged[n_staged] = '{unit: unit, term: term, last: 1'b0};
                n_staged++;
            end
        endfunction

        // Drop the unit once the string has used up its capacity
        function void emit(logic [15:0] unit);
            if (buffer_full())
                return;
            stage(unit, 1'b0);
            units = units + 16'd1;
        endfunction

        // Start a lead or pass the byte through, nothing held
        function void fresh_byte(logic [7:0] b);
            if (buffer_full())
                return;
            if (is_lead2(b) || is_lead3(b)) begin
                held_lead = b;
                hold_cnt  = u8d_pkg::HOLD_LEAD;
            end else begin
                emit({8'h00, b});
            end
        endfunction

        // Predict the units caused by one accepted byte
        function void note_byte(logic [7:0] b);
            u8d_pkg::t_hold_cnt cnt;
            logic [7:0]         lead;
            logic [7:0]         cont;
            cnt      = hold_cnt;
            lead     = held_lead;
            cont     = held_cont;
            n_staged = 0;
            hold_cnt = u8d_pkg::HOLD_NONE;
            if (b == 8'h00) begin
                // flush held bytes raw, then the terminator
                if (cnt != u8d_pkg::HOLD_NONE)
                    emit({8'h00, lead});
                if (cnt == u8d_pkg::HOLD_BOTH)
                    emit({8'h00, cont});
                stage(16'h0000, 1'b1);
                held_lead = '0;
                held_cont = '0;
                units     = '0;
            end else if (cnt == u8d_pkg::HOLD_LEAD) begin
                if (is_lead2(lead) && is_cont(b)) begin
                    emit({5'b0, lead[4:0], b[5:0]});
                end else if (is_lead3(lead) && is_cont(b)) begin
                    held_cont = b;
                    hold_cnt  = u8d_pkg::HOLD_BOTH;
                end else begin
                    emit({8'h00, lead});
                    fresh_byte(b);
                end
            end else if (cnt == u8d_pkg::HOLD_BOTH) begin
                if (is_cont(b)) begin
                    emit({lead[3:0], cont[5:0], b[5:0]});
                end else begin
                    emit({8'h00, lead});
                    emit({8'h00, cont});
                    fresh_byte(b);
                end
            end else begin
                fresh_byte(b);
            end
            for (int i = 0; i < n_staged; i++) begin
                staged[i].last = (i == n_staged - 1);
                expected_units.push_back(staged[i]);
            end
        endfunction

        // Compare one output transfer with the oldest prediction
        function void check_unit(logic [15:0] unit, logic term, logic last);
            t_unit_result want;
            if (expected_units.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected unit %h term %b last %b", unit, term, last);
                return;
            end
            want = expected_units.pop_front();
            if (want.unit !== unit || want.term !== term || want.last !== last) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected unit %h term %b last %b, got %h %b %b",
                             want.unit, want.term, want.last, unit, term, last);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] in_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [15:0] code_unit
    logic        m_axis_tuser;         // [0] is_terminator
    logic        m_axis_tlast;

    utf16_scoreboard sb = new();
    int  tx_count = 0;
    bit  tx_burst = 1'b0;
    bit  rx_burst = 1'b0;

    always #5 i_clk = ~i_clk;

    utf8_to_utf16_bmp_decoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    // Offer one byte after a random gap and hold it until the transfer
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_byte(b);
        tx_count++;
    endtask

    // Hold off the input until every predicted unit has left, then settle
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [15:0] v);
        wait_drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_capacity(v);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly well-formed sequences, some stray and broken ones
    task automatic send_token();
        logic [7:0] lead;
        case ($urandom_range(0, 9))
            0, 1, 2: send_byte(8'($urandom_range(1, 127)));
            3, 4: begin
                send_byte(8'($urandom_range(8'hC0, 8'hDF)));
                send_byte(8'($urandom_range(8'h80, 8'hBF)));
            end
            5, 6: begin
                send_byte(8'($urandom_range(8'hE0, 8'hEF)));
                send_byte(8'($urandom_range(8'h80, 8'hBF)));
                send_byte(8'($urandom_range(8'h80, 8'hBF)));
            end
            7: send_byte(8'($urandom_range(1, 255)));
            8: begin
                lead = $urandom_range(0, 1) ? 8'($urandom_range(8'hC0, 8'hDF))
                                            : 8'($urandom_range(8'hE0, 8'hEF));
                send_byte(lead);
            end
            default: begin
                send_byte(8'($urandom_range(8'hE0, 8'hEF)));
                send_byte(8'($urandom_range(8'h80, 8'hBF)));
            end
        endcase
    endtask

    // Output side: random stall per unit, check every transfer
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            sb.check_unit(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // Stimulus
    initial begin
        logic [7:0]  dir_bytes[$];
        logic [15:0] cap;
        int          n_str;
        int          n_tok;
        bit          paused;
        paused = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset capacity: ASCII, two- and three-byte forms, overlong, largest BMP unit
        dir_bytes = '{8'h41, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hC0, 8'h80,
                      8'hEF, 8'hBF, 8'hBF, 8'h00};
        foreach (dir_bytes[i]) send_byte(dir_bytes[i]);
        // Failed continuations and a flush of two held bytes at the zero byte
        dir_bytes = '{8'hC3, 8'h41, 8'hE2, 8'h82, 8'h41, 8'hE2, 8'h82, 8'h00};
        foreach (dir_bytes[i]) send_byte(dir_bytes[i]);
        // Capacity zero acts as one: only the terminator comes out
        write_capacity(16'd0);
        dir_bytes = '{8'hE2, 8'h41, 8'h00};
        foreach (dir_bytes[i]) send_byte(dir_bytes[i]);
        // Full buffer, then a capacity change in the middle of the string
        write_capacity(16'd2);
        send_byte(8'h80);
        send_byte(8'h42);
        write_capacity(16'hFFFF);
        send_byte(8'hFF);
        send_byte(8'h00);

        // Random strings in phases of one capacity each
        while (tx_count < 440) begin
            case ($urandom_range(0, 6))
                0: cap = 16'd1;
                1: cap = 16'd0;
                2, 3: cap = 16'($urandom_range(2, 8));
                4: cap = 16'd256;
                5: cap = 16'hFFFF;
                default: cap = 16'($urandom_range(1, 65535));
            endcase
            write_capacity(cap);
            tx_burst = ($urandom_range(0, 4) == 0);
            rx_burst = ($urandom_range(0, 4) == 0);
            n_str = $urandom_range(1, 3);
            repeat (n_str) begin
                n_tok = $urandom_range(0, 10);
                repeat (n_tok) begin
                    send_token();
                    if (!paused && tx_count >= 250) begin
                        wait_drain();
                        paused = 1'b1;
                    end
                end
                send_byte(8'h00);
            end
        end

        wait_drain();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
